### rtl/core/cvbm_pkg.sv
package cvbm_pkg;

   localparam int MaxChunks = 16;
   localparam int IdxW      = $clog2(MaxChunks);
   localparam int CntW      = $clog2(MaxChunks + 1);

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic [2:0] ST_APPENDED = 3'd0;
   localparam logic [2:0] ST_BAD_SIZE = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_SEGMENT  = 3'd3;
   localparam logic [2:0] ST_DUMMY    = 3'd4;
   localparam logic [2:0] ST_NOTHING  = 3'd5;
   localparam logic [2:0] ST_PAST_END = 3'd6;
   localparam logic [2:0] ST_CLEARED  = 3'd7;

   localparam logic [0:0] CSR_BLOCK_SIZE = 1'd0;
   localparam logic [0:0] CSR_MAX_CHUNK  = 1'd1;

   localparam int DivW = 57;

   // divider control between sequencer and divide unit
   typedef struct packed {
      logic        start;
      logic [DivW-1:0] dividend;
      logic [16:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [DivW-1:0] quotient;
      logic            rem_zero;
   } div_rsp_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  chunk_index;
      logic [31:0] block_in_chunk;
      logic [31:0] segment_blocks;
      logic [31:0] buffer_block_offset;
      logic [31:0] total_blocks;
      logic        last;
   } result_type;

endpackage

### rtl/core/cvbm_divider.sv
module cvbm_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  cvbm_pkg::div_req_type div_req,
   output cvbm_pkg::div_rsp_type div_rsp
);

   localparam int CW = $clog2(cvbm_pkg::DivW + 1);

   logic [cvbm_pkg::DivW-1:0] quo_ff, quo_in;
   logic [17:0]               rem_ff, rem_in;
   logic [16:0]               dsr_ff, dsr_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [17:0]               trial;

   // restoring division, one quotient bit per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[16:0], quo_ff[cvbm_pkg::DivW-1]};
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         cnt_in  = CW'(cvbm_pkg::DivW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[cvbm_pkg::DivW-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in    = trial - {1'b0, dsr_ff};
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
   assign div_rsp.rem_zero = (rem_ff == '0);

`ifndef ASSERT_OFF
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without busy");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !done_ff) else $error("divider done while busy");
   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0) else $error("divider count ran out");
`endif

endmodule

### rtl/core/chunked_volume_block_mapper.sv
// Channel | Dir | Contents
// req_*   | in  | tdata {block_count, first_block, dummy_blocks, chunk_bytes, is_dummy, opcode}
// rsp_*   | out | tdata {total, buf_off, seg, bic, chunk_index, status}, tlast = last
// csr_*   | in  | index 0 block_size, 1 max_chunk_bytes
// Steps after a request is taken:
// Clear and unknown opcode: result, then hand-off. Append: start the bit-serial
// 57-bit divider, its steps, check, hand-off; the check ends at once if block_size is zero.
// A dummy chunk first runs the shift-add multiply.
// Read: a scan past table entries, a decision, one result per segment, then
// hand-off. A result that waits on rsp_tready holds the sequence.
// Reset is synchronous; it empties the table. The block takes no request until
// every result of the last one has been taken; rsp stalls hold the sequencer.
module chunked_volume_block_mapper (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[1:0] is_dummy[2] chunk_bytes[42:3] dummy_blocks[74:43]
   // first_block[106:75] block_count[138:107], zero pad to 144
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[2:0] chunk_index[6:3] block_in_chunk[38:7] segment_blocks[70:39]
   // buffer_block_offset[102:71] total_blocks[134:103], zero pad to 136
   output logic [135:0] rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [39:0]  csr_wdata
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_MUL   = 8'b0000_0010,
      S_DIV   = 8'b0000_0100,
      S_CHECK = 8'b0000_1000,
      S_SCAN  = 8'b0001_0000,
      S_SEG   = 8'b0010_0000,
      S_OUT   = 8'b0100_0000,
      S_WAIT  = 8'b1000_0000
   } state_type;

   localparam int IW = cvbm_pkg::IdxW;
   localparam int CW = cvbm_pkg::CntW;

   state_type state_ff, state_in;

   logic [16:0] blk_size_ff;
   logic [39:0] max_bytes_ff;

   logic [31:0] end_mem [cvbm_pkg::MaxChunks];
   logic        dum_mem [cvbm_pkg::MaxChunks];
   logic [CW-1:0] count_ff, count_in;

   // request payload
   logic [1:0]  op_ff;
   logic        dum_ff;
   logic [31:0] want_ff;

   // work registers
   logic [56:0] acc_ff, acc_in;
   logic [31:0] mcand_ff, mcand_in;
   logic [5:0]  step_ff, step_in;
   logic [CW-1:0] n_ff, n_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] done_ff, done_in;
   logic [31:0] cur_ff, cur_in;

   cvbm_pkg::result_type res_ff, res_in;
   logic rsp_v_ff, rsp_v_in;
   logic wr_en;
   logic [31:0] wr_data;

   cvbm_pkg::div_req_type div_req;
   cvbm_pkg::div_rsp_type div_rsp;

   logic [31:0] total_now;
   logic [IW-1:0] n_idx;
   logic [31:0] end_n, len_raw, len, left;
   logic [32:0] sum;

   cvbm_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   assign n_idx     = n_ff[IW-1:0];
   assign end_n     = end_mem[n_idx];
   assign total_now = (count_ff == '0) ? '0 : end_mem[IW'(count_ff - 1'b1)];
   assign left      = want_ff - done_ff;
   assign len_raw   = end_n - cur_ff;
   assign len       = (left < len_raw) ? left : len_raw;
   assign sum       = {1'b0, total_now} + {1'b0, div_rsp.quotient[31:0]};

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tlast  = res_ff.last;
   assign rsp_tdata  = {1'b0, res_ff.total_blocks, res_ff.buffer_block_offset,
                        res_ff.segment_blocks, res_ff.block_in_chunk,
                        res_ff.chunk_index, res_ff.status};

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      step_in  = step_ff;
      n_in     = n_ff;
      start_in = start_ff;
      done_in  = done_ff;
      cur_in   = cur_ff;
      res_in   = res_ff;
      rsp_v_in = rsp_v_ff;
      wr_en    = 1'b0;
      wr_data  = sum[31:0];
      div_req  = '{start: 1'b0, dividend: acc_ff, divisor: blk_size_ff};
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               n_in     = '0;
               start_in = '0;
               done_in  = '0;
               cur_in   = req_tdata[106:75];
               acc_in   = '0;
               mcand_in = req_tdata[74:43];
               step_in  = '0;
               case (req_tdata[1:0])
                  cvbm_pkg::OP_CLEAR:  state_in = S_OUT;
                  cvbm_pkg::OP_APPEND: state_in = req_tdata[2] ? S_MUL : S_DIV;
                  cvbm_pkg::OP_READ:   state_in = S_SCAN;
                  default:             state_in = S_OUT;
               endcase
               if (req_tdata[1:0] == cvbm_pkg::OP_APPEND && !req_tdata[2]) begin
                  acc_in = {17'b0, req_tdata[42:3]};
               end
            end
         end
         S_MUL: begin
            // shift-add: acc = dummy_blocks * block_size, one bit a cycle
            if (mcand_ff[31]) begin
               acc_in = {acc_ff[55:0], 1'b0} + {40'b0, blk_size_ff};
            end else begin
               acc_in = {acc_ff[55:0], 1'b0};
            end
            mcand_in = {mcand_ff[30:0], 1'b0};
            step_in  = step_ff + 1'b1;
            if (step_ff == 6'd31) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            div_req.start = 1'b1;
            state_in      = S_CHECK;
         end
         S_CHECK: begin
            if (blk_size_ff == '0) begin
               res_in   = '{status: cvbm_pkg::ST_BAD_SIZE, total_blocks: total_now,
                            last: 1'b1, default: '0};
               rsp_v_in = 1'b1;
               state_in = S_WAIT;
            end else if (div_rsp.done) begin
               res_in   = '{status: cvbm_pkg::ST_BAD_SIZE, total_blocks: total_now,
                            last: 1'b1, default: '0};
               rsp_v_in = 1'b1;
               state_in = S_WAIT;
               if (div_rsp.quotient == '0 || !div_rsp.rem_zero
                   || acc_ff > {17'b0, max_bytes_ff}) begin
                  res_in.status = cvbm_pkg::ST_BAD_SIZE;
               end else if (count_ff >= CW'(cvbm_pkg::MaxChunks)
                            || div_rsp.quotient[56:32] != '0 || sum[32]) begin
                  res_in.status = cvbm_pkg::ST_FULL;
               end else begin
                  wr_en                 = 1'b1;
                  count_in              = count_ff + 1'b1;
                  res_in.status         = cvbm_pkg::ST_APPENDED;
                  res_in.chunk_index    = 4'(count_ff);
                  res_in.segment_blocks = div_rsp.quotient[31:0];
                  res_in.total_blocks   = sum[31:0];
               end
            end
         end
         S_SCAN: begin
            // walk entries until first_block falls inside one or the table ends
            if (n_ff < count_ff && cur_ff >= end_n) begin
               n_in     = n_ff + 1'b1;
               start_in = end_n;
            end else if (want_ff == '0 || n_ff >= count_ff) begin
               res_in   = '{status: cvbm_pkg::ST_NOTHING, total_blocks: total_now,
                            last: 1'b1, default: '0};
               rsp_v_in = 1'b1;
               state_in = S_WAIT;
            end else begin
               state_in = S_SEG;
            end
         end
         S_SEG: begin
            if (!rsp_v_ff || rsp_tready) begin
               rsp_v_in = 1'b1;
               res_in.chunk_index         = 4'(n_ff);
               res_in.block_in_chunk      = cur_ff - start_ff;
               res_in.total_blocks        = total_now;
               res_in.buffer_block_offset = done_ff;
               if (dum_mem[n_idx]) begin
                  res_in.status         = cvbm_pkg::ST_DUMMY;
                  res_in.segment_blocks = '0;
                  res_in.last           = 1'b1;
                  state_in              = S_WAIT;
               end else begin
                  res_in.segment_blocks = len;
                  done_in  = done_ff + len;
                  cur_in   = cur_ff + len;
                  start_in = end_n;
                  n_in     = n_ff + 1'b1;
                  if (len == left) begin
                     res_in.status = cvbm_pkg::ST_SEGMENT;
                     res_in.last   = 1'b1;
                     state_in      = S_WAIT;
                  end else if (n_ff + 1'b1 >= count_ff) begin
                     res_in.status = cvbm_pkg::ST_PAST_END;
                     res_in.last   = 1'b1;
                     state_in      = S_WAIT;
                  end else begin
                     res_in.status = cvbm_pkg::ST_SEGMENT;
                     res_in.last   = 1'b0;
                  end
               end
            end else if (rsp_tready) begin
               rsp_v_in = 1'b0;
            end
         end
         S_OUT: begin
            if (op_ff == cvbm_pkg::OP_CLEAR) begin
               count_in = '0;
               res_in   = '{status: cvbm_pkg::ST_CLEARED, last: 1'b1, default: '0};
            end else begin
               res_in   = '{status: cvbm_pkg::ST_NOTHING, total_blocks: total_now,
                            last: 1'b1, default: '0};
            end
            rsp_v_in = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (rsp_tready) begin
               rsp_v_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_SEG && rsp_v_ff && rsp_tready && state_in == S_SEG
          && rsp_v_in && res_in.last == 1'b0 && res_ff.last == 1'b0) begin
         rsp_v_in = 1'b1;
      end
   end

   // table memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         end_mem[IW'(count_ff)] <= wr_data;
         dum_mem[IW'(count_ff)] <= dum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         op_ff    <= req_tdata[1:0];
         dum_ff   <= req_tdata[2];
         want_ff  <= req_tdata[138:107];
      end
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      step_ff  <= step_in;
      n_ff     <= n_in;
      start_ff <= start_in;
      done_ff  <= done_in;
      cur_ff   <= cur_in;
      res_ff   <= res_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_v_ff     <= 1'b0;
         blk_size_ff  <= 17'd2048;
         max_bytes_ff <= 40'd2147483647;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_v_ff <= rsp_v_in;
         if (csr_we && csr_index == cvbm_pkg::CSR_BLOCK_SIZE) begin
            blk_size_ff <= csr_wdata[16:0];
         end
         if (csr_we && csr_index == cvbm_pkg::CSR_MAX_CHUNK) begin
            max_bytes_ff <= csr_wdata;
         end
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(cvbm_pkg::MaxChunks)) else $error("chunk count overflow");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_v_ff) else $error("ready while result pending");
   a_wait_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WAIT |-> rsp_v_ff && res_ff.last) else $error("wait without final");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && !rsp_tready |=> rsp_v_ff && $stable(res_ff)) else $error("result dropped");
`endif

endmodule
